// ===== rtl/vsd_pkg.sv =====
package vsd_pkg;

    localparam int VALUE_W         = 64;
    localparam int COUNT_W         = 4;
    localparam int BYTE_W          = 8;
    localparam int DEFAULT_MAX_BYTES   = 10;
    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] CONT_MASK    = 8'h80;
    localparam logic [BYTE_W-1:0] PAYLOAD_MASK = 8'h7F;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] used;
        logic               err;
    } item_t;

endpackage

// ===== rtl/vsd_front.sv =====
module vsd_front #(
    parameter int MAX_BYTES = vsd_pkg::DEFAULT_MAX_BYTES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [vsd_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          in_last,
    input  logic                          q_full,
    output logic                          in_ready,
    output logic                          push,
    output vsd_pkg::item_t                push_item
);

    localparam logic [vsd_pkg::COUNT_W-1:0] MAX_CNT = vsd_pkg::COUNT_W'(MAX_BYTES);

    logic [vsd_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic [vsd_pkg::COUNT_W-1:0] cnt_reg, cnt_next;

    logic                        accept;
    logic                        more;
    logic [7:0]                  shift;
    logic [vsd_pkg::VALUE_W-1:0] group;
    logic [vsd_pkg::VALUE_W-1:0] acc_sum;
    logic [vsd_pkg::COUNT_W-1:0] cnt_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign more     = (in_byte & vsd_pkg::CONT_MASK) != '0;
    assign shift    = {4'b0, cnt_reg} * 8'd7;
    assign cnt_inc  = cnt_reg + vsd_pkg::COUNT_W'(1);

    always_comb
    begin
        group = vsd_pkg::VALUE_W'(in_byte & vsd_pkg::PAYLOAD_MASK) << shift[5:0];
        if (shift[7:6] != 2'b00)
        begin
            group = '0;
        end
        acc_sum = acc_reg + group;
    end

    always_comb
    begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        push      = 1'b0;
        push_item = '0;
        if (accept)
        begin
            if (!more)
            begin
                push            = 1'b1;
                push_item.value = acc_sum;
                push_item.used  = cnt_inc;
                push_item.err   = 1'b0;
                acc_next        = '0;
                cnt_next        = '0;
            end
            else if (cnt_inc >= MAX_CNT || in_last)
            begin
                push          = 1'b1;
                push_item.err = 1'b1;
                acc_next      = '0;
                cnt_next      = '0;
            end
            else
            begin
                acc_next = acc_sum;
                cnt_next = cnt_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/vsd_queue.sv =====
module vsd_queue #(
    parameter int DEPTH = vsd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vsd_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output vsd_pkg::item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    vsd_pkg::item_t    slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    assign full       = cnt_reg == CNT_W'(DEPTH);
    assign head_valid = cnt_reg != '0;
    assign head_item  = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + CNT_W'(1);
            2'b01:   cnt_next = cnt_reg - CNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/vsd_back.sv =====
module vsd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           signed_mode,
    input  logic           head_valid,
    input  vsd_pkg::item_t head_item,
    input  logic           out_ready,
    output logic           pop,
    output logic           out_valid,
    output vsd_pkg::item_t out_item
);

    logic                        out_valid_reg, out_valid_next;
    vsd_pkg::item_t              out_item_reg;
    vsd_pkg::item_t              result;
    logic [vsd_pkg::VALUE_W-1:0] mag;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        mag    = head_item.value >> 1;
        result = head_item;
        if (signed_mode)
        begin
            result.value = head_item.value[0] ? (vsd_pkg::VALUE_W'(0) - mag) : mag;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== rtl/varint_stream_decoder_top.sv =====
// Channel    | Direction | Signals                  | Contents
// s (input)  | in        | s_tvalid/tready/tdata/tlast | tdata: in_byte; tlast: stream_end
// m (result) | out       | m_tvalid/tready/tdata/tuser | tdata: value_bits, bytes_used; tuser: decode_error
// cfg        | in        | cfg_we/cfg_wdata         | signed_mode
//
// One byte per cycle while s_tready is high; the front adds each payload group into the
// accumulator in the cycle the byte transfers; a result goes through the queue to the output register.
// Reset is asynchronous, active low, and clears the accumulator, byte count, queue and mode.
// A stalled master side fills the two-entry queue; s_tready drops only when it is full.
module varint_stream_decoder_top #(
    parameter int MAX_BYTES   = vsd_pkg::DEFAULT_MAX_BYTES,
    parameter int QUEUE_DEPTH = vsd_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] value_bits, [67:64] bytes_used, [71:68] zero
    output logic        m_tuser    // decode_error
);

    logic           signed_mode_reg;
    logic           q_full;
    logic           push;
    vsd_pkg::item_t push_item;
    logic           pop;
    logic           head_valid;
    vsd_pkg::item_t head_item;
    vsd_pkg::item_t out_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            signed_mode_reg <= cfg_wdata;
        end
    end

    vsd_front #(
        .MAX_BYTES (MAX_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .q_full    (q_full),
        .in_ready  (s_tready),
        .push      (push),
        .push_item (push_item)
    );

    vsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    vsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .signed_mode (signed_mode_reg),
        .head_valid  (head_valid),
        .head_item   (head_item),
        .out_ready   (m_tready),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_item    (out_item)
    );

    assign m_tdata = {4'b0000, out_item.used, out_item.value};
    assign m_tuser = out_item.err;

endmodule
